>>> sv/lzo_pkg.sv
`timescale 1ns / 1ps
package lzo_pkg;

  typedef enum logic [3:0] {
    PH_FIRST      = 4'd0,
    PH_TOK_MAIN   = 4'd1,
    PH_TOK_FLM    = 4'd2,
    PH_TOK_MATCH  = 4'd3,
    PH_LIT_RUN    = 4'd4,
    PH_LIT_TRAIL  = 4'd5,
    PH_LEN_LIT    = 4'd6,
    PH_LEN_MATCH  = 4'd7,
    PH_DIST_SHORT = 4'd8,
    PH_DIST_FLM   = 4'd9,
    PH_DIST_LO    = 4'd10,
    PH_DIST_HI    = 4'd11,
    PH_COPY       = 4'd12,
    PH_STATUS     = 4'd13,
    PH_DONE       = 4'd14
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_INPUT        = 3'd1,
    ST_OUTPUT       = 3'd2,
    ST_LOOKBEHIND   = 3'd3,
    ST_EOF          = 3'd4,
    ST_NOT_CONSUMED = 3'd5
  } status_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic        pend;
    logic [31:0] count;
  } res_t;

  localparam logic [15:0] FLM_DIST_BASE = 16'h0801;
  localparam logic [15:0] FAR_DIST_BASE = 16'h4000;

endpackage

>>> sv/lzo1x_stream_decompressor.sv
`timescale 1ns / 1ps
// Each result word is registered in the output register, or the skid when stalled.
// Throughput: one word per cycle (compressed byte or copy tick) while not stalled.
// The history read for the next copy byte is issued from the next write pointer
// and registered, forwarding the byte written in the same cycle for distance one.
// Reset clears all control state and sets the capacity to its maximum; the
// history memory is not cleared, as only written entries are ever read.
module lzo1x_stream_decompressor
  import lzo_pkg::*;
#(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic        copy_pending_o,
  output logic [31:0] written_count_o
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  phase_e      phase_q, phase_d;
  logic [31:0] cap_q;
  logic [31:0] count_q, count_d;
  logic [7:0]  tok_q, tok_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] dist_q, dist_d;
  logic [31:0] rem_q, rem_d;
  logic [1:0]  trail_q, trail_d;
  logic [AW-1:0] wp_q, wp_d, wp_inc, raddr;

  logic [7:0]  hist_mem [HISTORY_DEPTH];
  logic [7:0]  rd_q, fwd_byte_q, hist_val;
  logic        fwd_q;
  logic        hist_we;
  logic [7:0]  hist_wdata;

  logic        acc_in;
  res_t        res, out_q, skid_q;
  logic        res_valid, out_valid_q, skid_valid_q, out_take;

  logic        room_ok;
  logic [31:0] room;
  logic [7:0]  b;
  logic [8:0]  len_base, len_add;
  logic [32:0] len_sum;
  logic [33:0] lit_cnt;
  logic        lits_full;
  logic [15:0] m_dist;
  logic [32:0] m_len;
  logic [1:0]  m_trail;
  logic        m_far, m_full, m_trail_full;
  logic [13:0] dlow;
  logic        fin;
  status_e     fin_st;
  logic [31:0] fin_cnt;
  phase_e      lit_next;
  logic        lit_go;

  assign b       = data_byte_i;
  assign acc_in  = in_valid_i && !in_stall_o;
  assign room_ok = count_q <= cap_q;
  assign room    = cap_q - count_q;
  assign dlow    = {b, low_q[7:2]};

  assign len_base = (phase_q == PH_LEN_LIT) ? 9'd15 : ((tok_q >= 8'd32) ? 9'd31 : 9'd7);
  assign len_add  = (b == 8'd0) ? 9'd255 : (len_base + {1'b0, b});
  assign len_sum  = {1'b0, acc_q} + {24'd0, len_add};

  always_comb begin
    case (phase_q)
      PH_FIRST:   lit_cnt = (b > 8'd17) ? {26'd0, b - 8'd17} : {26'd0, b} + 34'd3;
      PH_LEN_LIT: lit_cnt = {1'b0, len_sum} + 34'd3;
      default:    lit_cnt = {26'd0, b} + 34'd3;
    endcase
  end
  assign lits_full = !room_ok || (lit_cnt > {2'b00, room});

  always_comb begin
    case (phase_q)
      PH_DIST_SHORT: begin
        if (tok_q >= 8'd64) begin
          m_dist = 16'd1 + {13'd0, tok_q[4:2]} + {5'd0, b, 3'd0};
          m_len  = {30'd0, tok_q[7:5]} + 33'd1;
        end else begin
          m_dist = 16'd1 + {10'd0, tok_q[7:2]} + {6'd0, b, 2'd0};
          m_len  = 33'd2;
        end
        m_trail = tok_q[1:0];
      end
      PH_DIST_FLM: begin
        m_dist  = FLM_DIST_BASE + {10'd0, tok_q[7:2]} + {6'd0, b, 2'd0};
        m_len   = 33'd3;
        m_trail = tok_q[1:0];
      end
      default: begin
        if (tok_q >= 8'd32) begin
          m_dist = 16'd1 + {2'd0, dlow};
        end else begin
          m_dist = {1'b0, tok_q[3], 14'd0} + {2'd0, dlow} + FAR_DIST_BASE;
        end
        m_len   = {1'b0, acc_q} + 33'd2;
        m_trail = low_q[1:0];
      end
    endcase
  end
  assign m_far  = (m_dist == 16'd0) || ({16'd0, m_dist} > count_q);
  assign m_full = !room_ok || (m_len[31:0] > room);
  assign m_trail_full = ({2'b00, m_len[31:0]} + {32'd0, m_trail}) > {2'b00, room};

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    tok_d      = tok_q;
    acc_d      = acc_q;
    low_d      = low_q;
    dist_d     = dist_q;
    rem_d      = rem_q;
    trail_d    = trail_q;
    hist_we    = 1'b0;
    hist_wdata = b;
    res_valid  = 1'b0;
    res        = '0;
    fin        = 1'b0;
    fin_st     = ST_OK;
    fin_cnt    = count_q;
    lit_go     = 1'b0;
    lit_next   = PH_LIT_RUN;

    if (acc_in) begin
      if (cmd_i == CMD_TICK) begin
        if (phase_q == PH_COPY) begin
          hist_we    = 1'b1;
          hist_wdata = hist_val;
          count_d    = count_q + 32'd1;
          rem_d      = rem_q - 32'd1;
          res_valid  = 1'b1;
          res.data   = hist_val;
          res.pend   = 1'b1;
          res.count  = count_q + 32'd1;
          if (rem_q == 32'd1) begin
            if (tok_q != 8'd0) begin
              phase_d = PH_STATUS;
            end else if (trail_q == 2'd0) begin
              phase_d  = PH_TOK_MAIN;
              res.pend = 1'b0;
            end else begin
              rem_d    = {30'd0, trail_q};
              acc_d    = {30'd0, trail_q};
              phase_d  = PH_LIT_TRAIL;
              res.pend = 1'b0;
            end
          end
        end else if (phase_q == PH_STATUS) begin
          fin    = 1'b1;
          fin_st = status_e'(tok_q[2:0]);
        end
      end else begin
        case (phase_q)
          PH_FIRST, PH_TOK_MAIN, PH_TOK_FLM, PH_TOK_MATCH: begin
            if (phase_q == PH_FIRST && b > 8'd17) begin
              lit_go   = 1'b1;
              lit_next = (b < 8'd21) ? PH_LIT_TRAIL : PH_LIT_RUN;
            end else if ((phase_q == PH_FIRST || phase_q == PH_TOK_MAIN) && b < 8'd16) begin
              if (b == 8'd0) begin
                if (last_byte_i) begin
                  fin    = 1'b1;
                  fin_st = ST_INPUT;
                end else begin
                  acc_d   = 32'd0;
                  phase_d = PH_LEN_LIT;
                end
              end else begin
                lit_go = 1'b1;
              end
            end else if (last_byte_i) begin
              fin    = 1'b1;
              fin_st = ST_INPUT;
            end else begin
              tok_d = b;
              if (phase_q == PH_TOK_FLM && b < 8'd16) begin
                phase_d = PH_DIST_FLM;
              end else if (b >= 8'd64 || b < 8'd16) begin
                phase_d = PH_DIST_SHORT;
              end else begin
                acc_d   = (b >= 8'd32) ? {27'd0, b[4:0]} : {29'd0, b[2:0]};
                phase_d = (acc_d != 32'd0) ? PH_DIST_LO : PH_LEN_MATCH;
              end
            end
          end
          PH_LIT_RUN, PH_LIT_TRAIL: begin
            if (last_byte_i) begin
              fin     = 1'b1;
              fin_st  = ST_INPUT;
              fin_cnt = count_q - (acc_q - rem_q);
            end else begin
              hist_we   = 1'b1;
              count_d   = count_q + 32'd1;
              rem_d     = rem_q - 32'd1;
              res_valid = 1'b1;
              res.data  = b;
              res.count = count_q + 32'd1;
              if (rem_q == 32'd1) begin
                phase_d = (phase_q == PH_LIT_RUN) ? PH_TOK_FLM : PH_TOK_MATCH;
              end
            end
          end
          PH_LEN_LIT: begin
            if (b == 8'd0) begin
              if (len_sum[32] || last_byte_i) begin
                fin    = 1'b1;
                fin_st = ST_INPUT;
              end else begin
                acc_d = len_sum[31:0];
              end
            end else if (lit_cnt[33:32] != 2'd0) begin
              fin    = 1'b1;
              fin_st = ST_INPUT;
            end else begin
              lit_go = 1'b1;
            end
          end
          PH_LEN_MATCH: begin
            if (len_sum[32] || last_byte_i) begin
              fin    = 1'b1;
              fin_st = ST_INPUT;
            end else begin
              acc_d = len_sum[31:0];
              if (b != 8'd0) begin
                phase_d = PH_DIST_LO;
              end
            end
          end
          PH_DIST_LO: begin
            low_d = b;
            if (last_byte_i) begin
              fin    = 1'b1;
              fin_st = ST_INPUT;
            end else begin
              phase_d = PH_DIST_HI;
            end
          end
          PH_DIST_SHORT, PH_DIST_FLM, PH_DIST_HI: begin
            if (phase_q == PH_DIST_HI && tok_q < 8'd32 && !tok_q[3] && dlow == 14'd0) begin
              fin    = 1'b1;
              fin_st = last_byte_i ? ST_OK : ST_NOT_CONSUMED;
            end else if (m_len[32]) begin
              fin    = 1'b1;
              fin_st = ST_INPUT;
            end else if (m_far) begin
              fin    = 1'b1;
              fin_st = ST_LOOKBEHIND;
            end else if (m_full) begin
              fin    = 1'b1;
              fin_st = ST_OUTPUT;
            end else begin
              if (m_trail == 2'd0) begin
                tok_d = last_byte_i ? {5'd0, ST_EOF} : 8'd0;
              end else if (m_trail_full) begin
                tok_d = {5'd0, ST_OUTPUT};
              end else begin
                tok_d = last_byte_i ? {5'd0, ST_INPUT} : 8'd0;
              end
              dist_d  = m_dist;
              rem_d   = m_len[31:0];
              trail_d = m_trail;
              phase_d = PH_COPY;
            end
          end
          default: begin
          end
        endcase
      end

      if (lit_go) begin
        if (lits_full) begin
          fin    = 1'b1;
          fin_st = ST_OUTPUT;
        end else if (last_byte_i) begin
          fin    = 1'b1;
          fin_st = ST_INPUT;
        end else begin
          rem_d   = lit_cnt[31:0];
          acc_d   = lit_cnt[31:0];
          phase_d = lit_next;
        end
      end

      if (fin) begin
        phase_d    = PH_DONE;
        res_valid  = 1'b1;
        res        = '0;
        res.kind   = 1'b1;
        res.status = fin_st;
        res.count  = fin_cnt;
      end
    end
  end

  assign wp_inc = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
  assign wp_d   = hist_we ? wp_inc : wp_q;

  always_comb begin
    if ({1'b0, wp_d} >= (AW + 1)'(dist_d)) begin
      raddr = wp_d - AW'(dist_d);
    end else begin
      raddr = AW'({1'b0, wp_d} + (AW + 1)'(HISTORY_DEPTH) - (AW + 1)'(dist_d));
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[wp_q] <= hist_wdata;
    end
    rd_q       <= hist_mem[raddr];
    fwd_q      <= hist_we && (raddr == wp_q);
    fwd_byte_q <= hist_wdata;
  end

  assign hist_val = fwd_q ? fwd_byte_q : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      cap_q   <= 32'hFFFF_FFFF;
      count_q <= '0;
      tok_q   <= '0;
      acc_q   <= '0;
      low_q   <= '0;
      dist_q  <= '0;
      rem_q   <= '0;
      trail_q <= '0;
      wp_q    <= '0;
    end else begin
      phase_q <= phase_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      count_q <= count_d;
      tok_q   <= tok_d;
      acc_q   <= acc_d;
      low_q   <= low_d;
      dist_q  <= dist_d;
      rem_q   <= rem_d;
      trail_q <= trail_d;
      wp_q    <= wp_d;
    end
  end

  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign out_byte_o      = out_q.data;
  assign status_o        = out_q.status;
  assign copy_pending_o  = out_q.pend;
  assign written_count_o = out_q.count;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held while the output register is empty");

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("decoder left the finished state");

  a_copy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_COPY |-> rem_q != 32'd0)
    else $error("copy phase with no bytes remaining");

  a_status_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.kind) |=> phase_q == PH_DONE)
    else $error("status word issued without finishing");

endmodule
